[rtl/efa_pkg.sv]
// shared types and constants for the event frame accumulator
package efa_pkg;

   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;
   localparam int COL_W       = 8;
   localparam int ROW_W       = 8;
   localparam int PIXEL_W     = 8;
   localparam int THRESH_W    = 7;
   localparam int COUNT_W     = 24;
   localparam int DIM_W       = 9;
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int STORE_AW    = $clog2(STORE_DEPTH);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_AW      = 4;
   localparam int CSR_DW      = 32;

   localparam logic [THRESH_W-1:0] THRESHOLD_RESET  = THRESH_W'(64);
   localparam logic [COUNT_W-1:0]  MAX_EVENTS_RESET = COUNT_W'(16777215);
   localparam logic [DIM_W-1:0]    WIDTH_RESET      = DIM_W'(240);
   localparam logic [DIM_W-1:0]    HEIGHT_RESET     = DIM_W'(180);

   typedef enum logic [1:0] {
      MODE_START = 2'd0,
      MODE_EVENT = 2'd1,
      MODE_READ  = 2'd2,
      MODE_NONE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      REG_THRESHOLD    = 2'd0,
      REG_MAX_EVENTS   = 2'd1,
      REG_FRAME_WIDTH  = 2'd2,
      REG_FRAME_HEIGHT = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [THRESH_W-1:0] threshold;
      logic [COUNT_W-1:0]  max_events;
      logic [DIM_W-1:0]    used_width;
      logic [DIM_W-1:0]    used_height;
   } cfg_type;

   typedef struct packed {
      mode_type         kind;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             polarity;
      logic             in_frame;
   } cmd_type;

   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } enq_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } deq_type;

endpackage

[rtl/efa_req_if.sv]
// request channel interface
interface efa_req_if;
   import efa_pkg::*;

   logic             valid;
   logic             ready;
   logic [1:0]       mode;
   logic [COL_W-1:0] col;
   logic [ROW_W-1:0] row;
   logic             polarity;

   modport source (output valid, output mode, output col, output row, output polarity,
                   input ready);
   modport sink   (input valid, input mode, input col, input row, input polarity,
                   output ready);
endinterface

[rtl/efa_rsp_if.sv]
// response channel interface
interface efa_rsp_if;
   import efa_pkg::*;

   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel_value;
   logic               out_of_frame;

   modport source (output valid, output pixel_value, output out_of_frame, input ready);
   modport sink   (input valid, input pixel_value, input out_of_frame, output ready);
endinterface

[rtl/efa_ram.sv]
// generic single write port ram with registered read
module efa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/efa_front.sv]
// front end: register file, request intake and classification
module efa_front (
   input  logic                        clock,
   input  logic                        reset,
   efa_req_if.sink                     req_bus,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [efa_pkg::CSR_AW-1:0]  paddr,
   input  logic [efa_pkg::CSR_DW-1:0]  pwdata,
   output logic [efa_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready,
   input  logic                        queue_full,
   output efa_pkg::enq_type            enq,
   output efa_pkg::cfg_type            cfg
);
   import efa_pkg::*;

   logic [THRESH_W-1:0] threshold_ff, threshold_in;
   logic [COUNT_W-1:0]  max_events_ff, max_events_in;
   logic [DIM_W-1:0]    width_ff, width_in;
   logic [DIM_W-1:0]    height_ff, height_in;
   reg_index_type       reg_sel;
   logic                wr_strobe;
   logic                accept;

   assign pready    = 1'b1;
   assign reg_sel   = reg_index_type'(paddr[CSR_AW-1:2]);
   assign wr_strobe = psel & penable & pwrite;

   always_comb begin
      threshold_in  = threshold_ff;
      max_events_in = max_events_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      if (wr_strobe) begin
         case (reg_sel)
            REG_THRESHOLD:    threshold_in  = pwdata[THRESH_W-1:0];
            REG_MAX_EVENTS:   max_events_in = pwdata[COUNT_W-1:0];
            REG_FRAME_WIDTH:  width_in      = pwdata[DIM_W-1:0];
            REG_FRAME_HEIGHT: height_in     = pwdata[DIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= THRESHOLD_RESET;
         max_events_ff <= MAX_EVENTS_RESET;
         width_ff      <= WIDTH_RESET;
         height_ff     <= HEIGHT_RESET;
      end else begin
         threshold_ff  <= threshold_in;
         max_events_ff <= max_events_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_THRESHOLD:    prdata = CSR_DW'(threshold_ff);
         REG_MAX_EVENTS:   prdata = CSR_DW'(max_events_ff);
         REG_FRAME_WIDTH:  prdata = CSR_DW'(width_ff);
         REG_FRAME_HEIGHT: prdata = CSR_DW'(height_ff);
         default:          prdata = '0;
      endcase
   end

   always_comb begin
      cfg.threshold   = threshold_ff;
      cfg.max_events  = max_events_ff;
      cfg.used_width  = (width_ff > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_ff;
      cfg.used_height = (height_ff > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_ff;
   end

   assign req_bus.ready = ~queue_full;
   assign accept        = req_bus.valid & ~queue_full;

   always_comb begin
      enq.cmd.kind     = mode_type'(req_bus.mode);
      enq.cmd.col      = req_bus.col;
      enq.cmd.row      = req_bus.row;
      enq.cmd.polarity = req_bus.polarity;
      enq.cmd.in_frame = ({1'b0, req_bus.col} < cfg.used_width) &&
                         ({1'b0, req_bus.row} < cfg.used_height);
      enq.push         = accept && (enq.cmd.kind != MODE_NONE);
   end
endmodule

[rtl/efa_queue.sv]
// short command queue between front and back
module efa_queue (
   input  logic             clock,
   input  logic             reset,
   input  efa_pkg::enq_type enq,
   output logic             full,
   input  logic             pop,
   output efa_pkg::deq_type deq
);
   import efa_pkg::*;

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push   = enq.push & ~full;
   assign do_pop    = pop & (count_ff != '0);
   assign deq.valid = (count_ff != '0);
   assign deq.cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= enq.cmd;
      end
   end
endmodule

[rtl/efa_back.sv]
// back end: frame fill sweep, pixel update, pixel read and response register
module efa_back (
   input  logic             clock,
   input  logic             reset,
   input  efa_pkg::cfg_type cfg,
   input  efa_pkg::deq_type deq,
   output logic             pop,
   efa_rsp_if.source        rsp_bus
);
   import efa_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_FILL   = 3'b010,
      ST_ACCESS = 3'b100
   } back_state_type;

   back_state_type      state_ff, state_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic [COL_W-1:0]    fill_col_ff, fill_col_in;
   logic [ROW_W-1:0]    fill_row_ff, fill_row_in;
   logic [COL_W-1:0]    last_col_ff, last_col_in;
   logic [ROW_W-1:0]    last_row_ff, last_row_in;
   logic [PIXEL_W-1:0]  fill_value_ff, fill_value_in;
   logic [STORE_AW-1:0] addr_ff, addr_in;
   logic                is_event_ff, is_event_in;
   logic                polarity_ff, polarity_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0]  pixel_ff, pixel_in;
   logic                oof_ff, oof_in;

   logic                slot_free;
   logic                wr_en;
   logic [STORE_AW-1:0] wr_addr;
   logic [PIXEL_W-1:0]  wr_data;
   logic                rd_en;
   logic [STORE_AW-1:0] rd_addr;
   logic [PIXEL_W-1:0]  rd_data;
   logic [PIXEL_W-1:0]  ceiling;
   logic [PIXEL_W-1:0]  updated;
   logic [STORE_AW-1:0] cmd_addr;

   efa_ram #(
      .WIDTH (PIXEL_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign slot_free = ~rsp_valid_ff | rsp_bus.ready;
   assign ceiling   = {cfg.threshold, 1'b0};
   assign cmd_addr  = STORE_AW'(deq.cmd.row) * STORE_AW'(MAX_WIDTH) + STORE_AW'(deq.cmd.col);

   always_comb begin
      if (polarity_ff) begin
         updated = (rd_data < ceiling) ? rd_data + 1'b1 : rd_data;
      end else begin
         updated = (rd_data != '0) ? rd_data - 1'b1 : rd_data;
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      fill_col_in   = fill_col_ff;
      fill_row_in   = fill_row_ff;
      last_col_in   = last_col_ff;
      last_row_in   = last_row_ff;
      fill_value_in = fill_value_ff;
      addr_in       = addr_ff;
      is_event_in   = is_event_ff;
      polarity_in   = polarity_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_bus.ready;
      pixel_in      = pixel_ff;
      oof_in        = oof_ff;
      pop           = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = addr_ff;
      wr_data       = updated;
      rd_en         = 1'b0;
      rd_addr       = cmd_addr;

      case (state_ff)
         ST_IDLE: begin
            if (deq.valid) begin
               case (deq.cmd.kind)
                  MODE_START: begin
                     pop           = 1'b1;
                     count_in      = '0;
                     fill_col_in   = '0;
                     fill_row_in   = '0;
                     last_col_in   = COL_W'(cfg.used_width - 1'b1);
                     last_row_in   = ROW_W'(cfg.used_height - 1'b1);
                     fill_value_in = PIXEL_W'(cfg.threshold);
                     if (cfg.used_width != '0 && cfg.used_height != '0) begin
                        state_in = ST_FILL;
                     end
                  end
                  MODE_EVENT: begin
                     pop = 1'b1;
                     if (deq.cmd.in_frame && count_ff < cfg.max_events) begin
                        rd_en       = 1'b1;
                        addr_in     = cmd_addr;
                        polarity_in = deq.cmd.polarity;
                        is_event_in = 1'b1;
                        count_in    = count_ff + 1'b1;
                        state_in    = ST_ACCESS;
                     end
                  end
                  MODE_READ: begin
                     if (slot_free) begin
                        pop = 1'b1;
                        if (deq.cmd.in_frame) begin
                           rd_en       = 1'b1;
                           is_event_in = 1'b0;
                           state_in    = ST_ACCESS;
                        end else begin
                           rsp_valid_in = 1'b1;
                           pixel_in     = '0;
                           oof_in       = 1'b1;
                        end
                     end
                  end
                  default: pop = 1'b1;
               endcase
            end
         end
         ST_FILL: begin
            wr_en   = 1'b1;
            wr_addr = STORE_AW'(fill_row_ff) * STORE_AW'(MAX_WIDTH) + STORE_AW'(fill_col_ff);
            wr_data = fill_value_ff;
            if (fill_col_ff == last_col_ff) begin
               fill_col_in = '0;
               fill_row_in = fill_row_ff + 1'b1;
               if (fill_row_ff == last_row_ff) begin
                  state_in = ST_IDLE;
               end
            end else begin
               fill_col_in = fill_col_ff + 1'b1;
            end
         end
         ST_ACCESS: begin
            if (is_event_ff) begin
               wr_en = 1'b1;
            end else begin
               rsp_valid_in = 1'b1;
               pixel_in     = rd_data;
               oof_in       = 1'b0;
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_col_ff   <= fill_col_in;
      fill_row_ff   <= fill_row_in;
      last_col_ff   <= last_col_in;
      last_row_ff   <= last_row_in;
      fill_value_ff <= fill_value_in;
      addr_ff       <= addr_in;
      is_event_ff   <= is_event_in;
      polarity_ff   <= polarity_in;
      pixel_ff      <= pixel_in;
      oof_ff        <= oof_in;
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.pixel_value  = pixel_ff;
   assign rsp_bus.out_of_frame = oof_ff;
endmodule

[rtl/event_frame_accumulator_core.sv]
// top level of the event frame accumulator
//
//   channel   direction  handshake            payload
//   req_bus   in         valid/ready          mode, col, row, polarity
//   rsp_bus   out        valid/ready          pixel_value, out_of_frame
//   apb       in         psel/penable/pready  paddr, pwdata, prdata
//
// an event or an in-frame read first reads the store in the back end, then updates the
// pixel or loads the response; an out-of-frame read or a dropped event needs no store read
// a frame start sweeps the store one pixel a cycle over used width times used height pixels
// requests are taken while the two-entry queue has room, also during a sweep
// a read waits in the queue while the response register is still held
// reset clears the event count, queue and response valid; pixel contents are kept
module event_frame_accumulator_core (
   input  logic                        clock,
   input  logic                        reset,
   efa_req_if.sink                     req_bus,
   efa_rsp_if.source                   rsp_bus,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [efa_pkg::CSR_AW-1:0]  paddr,
   input  logic [efa_pkg::CSR_DW-1:0]  pwdata,
   output logic [efa_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready
);
   import efa_pkg::*;

   cfg_type cfg;
   enq_type enq;
   deq_type deq;
   logic    queue_full;
   logic    pop;

   efa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .queue_full (queue_full),
      .enq        (enq),
      .cfg        (cfg)
   );

   efa_queue u_queue (
      .clock (clock),
      .reset (reset),
      .enq   (enq),
      .full  (queue_full),
      .pop   (pop),
      .deq   (deq)
   );

   efa_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .deq     (deq),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );
endmodule

[tb/efa_frame_checker.sv]
// request/response monitor with pixel-store prediction for the event frame accumulator
module efa_frame_checker
   import efa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   efa_req_if                req_mon,
   efa_rsp_if                rsp_mon,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic              pready,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output int                fail_count,
   output int                waiting_results,
   output int                reads_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [PIXEL_W-1:0] value;
      logic               outside;
   } pixel_read_type;

   pixel_read_type      expected_reads[$];
   logic [PIXEL_W-1:0]  pixel_levels [STORE_DEPTH];
   logic [COUNT_W-1:0]  frame_events;
   logic [THRESH_W-1:0] threshold;
   logic [COUNT_W-1:0]  event_cap;
   logic [DIM_W-1:0]    width_reg;
   logic [DIM_W-1:0]    height_reg;
   int                  failures = 0;
   int                  pending  = 0;
   int                  compared = 0;

   assign fail_count      = failures;
   assign waiting_results = pending;
   assign reads_checked   = compared;

   function automatic int clamp_span(logic [DIM_W-1:0] span, int limit);
      return (int'(span) > limit) ? limit : int'(span);
   endfunction

   task automatic advance_frame(mode_type kind, logic [COL_W-1:0] c, logic [ROW_W-1:0] r,
                                logic pol);
      int                 uw;
      int                 uh;
      int                 where;
      bit                 inside_frame;
      logic [PIXEL_W-1:0] level;
      logic [PIXEL_W-1:0] ceiling;
      pixel_read_type     read_back;
      uw = clamp_span(width_reg, MAX_WIDTH);
      uh = clamp_span(height_reg, MAX_HEIGHT);
      inside_frame = (int'(c) < uw) && (int'(r) < uh);
      where = int'(r) * MAX_WIDTH + int'(c);
      case (kind)
         MODE_START: begin
            for (int y = 0; y < uh; y++)
               for (int x = 0; x < uw; x++)
                  pixel_levels[y * MAX_WIDTH + x] = PIXEL_W'(threshold);
            frame_events = '0;
         end
         MODE_EVENT: begin
            if (inside_frame && frame_events < event_cap) begin
               level = pixel_levels[where];
               ceiling = {threshold, 1'b0};
               if (pol) begin
                  if (level < ceiling) level = level + 1'b1;
               end else if (level != '0) begin
                  level = level - 1'b1;
               end
               pixel_levels[where] = level;
               frame_events = frame_events + 1'b1;
            end
         end
         MODE_READ: begin
            read_back.value   = inside_frame ? pixel_levels[where] : '0;
            read_back.outside = !inside_frame;
            expected_reads.push_back(read_back);
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin
      pixel_read_type want;
      if (reset) begin
         expected_reads.delete();
         frame_events = '0;
         threshold    = THRESHOLD_RESET;
         event_cap    = MAX_EVENTS_RESET;
         width_reg    = WIDTH_RESET;
         height_reg   = HEIGHT_RESET;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[3:2]))
               REG_THRESHOLD:    threshold  = pwdata[THRESH_W-1:0];
               REG_MAX_EVENTS:   event_cap  = pwdata[COUNT_W-1:0];
               REG_FRAME_WIDTH:  width_reg  = pwdata[DIM_W-1:0];
               REG_FRAME_HEIGHT: height_reg = pwdata[DIM_W-1:0];
               default: begin
               end
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_reads.size() == 0) begin
               failures++;
               $display("%0t unexpected pixel response: value %0d out_of_frame %0b", $time,
                        rsp_mon.pixel_value, rsp_mon.out_of_frame);
            end else begin
               want = expected_reads.pop_front();
               compared++;
               if (rsp_mon.pixel_value !== want.value) begin
                  failures++;
                  $display("%0t pixel_value mismatch: expected %0d, actual %0d", $time,
                           want.value, rsp_mon.pixel_value);
               end
               if (rsp_mon.out_of_frame !== want.outside) begin
                  failures++;
                  $display("%0t out_of_frame mismatch: expected %0b, actual %0b", $time,
                           want.outside, rsp_mon.out_of_frame);
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            advance_frame(mode_type'(req_mon.mode), req_mon.col, req_mon.row, req_mon.polarity);
      end
      pending = expected_reads.size();
   end

endmodule

[tb/event_frame_accumulator_core_test.sv]
// stimulus, handshake pacing and verdict for the event frame accumulator
module event_frame_accumulator_core_test;
   timeunit 1ns;
   timeprecision 1ps;
   import efa_pkg::*;

   localparam int IDLE_LIMIT   = 400000;
   localparam int RANDOM_ITEMS = 1800;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [CSR_DW-1:0] pwdata;
   logic [CSR_DW-1:0] prdata;
   logic              pready;
   int                check_failures;
   int                check_pending;
   int                check_reads;

   efa_req_if req_bus ();
   efa_rsp_if rsp_bus ();

   event_frame_accumulator_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   efa_frame_checker frame_check (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .pready          (pready),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .fail_count      (check_failures),
      .waiting_results (check_pending),
      .reads_checked   (check_reads)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   int cfg_width     = 240;
   int cfg_height    = 180;
   bit written_pixels [STORE_DEPTH];
   int sweep_backlog = 0;
   bit steady        = 1'b0;
   bit hold_off_request = 1'b0;
   int up_bias       = 50;
   int starts_sent   = 0;
   int events_sent   = 0;
   int reads_sent    = 0;
   int unused_sent   = 0;
   int register_writes = 0;
   int phases        = 0;
   int idle_cycles   = 0;

   function automatic int used_span(int span, int limit);
      return (span > limit) ? limit : span;
   endfunction

   function automatic bit pick_pixel(output int c, output int r);
      int uw;
      int uh;
      uw = used_span(cfg_width, MAX_WIDTH);
      uh = used_span(cfg_height, MAX_HEIGHT);
      c = 0;
      r = 0;
      for (int tries = 0; tries < 8; tries++) begin
         if (uw == 0 || uh == 0 || $urandom_range(0, 3) == 0) begin
            c = $urandom_range(0, 255);
            r = $urandom_range(0, 255);
         end else if ($urandom_range(0, 1) == 0) begin
            c = $urandom_range(0, (uw > 1) ? 1 : 0);
            r = $urandom_range(0, (uh > 1) ? 1 : 0);
         end else begin
            c = $urandom_range(0, uw - 1);
            r = $urandom_range(0, uh - 1);
         end
         if (c >= uw || r >= uh || written_pixels[r * MAX_WIDTH + c]) return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic write_register(reg_index_type idx, logic [CSR_DW-1:0] value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_FRAME_WIDTH:  cfg_width  = int'(value[DIM_W-1:0]);
         REG_FRAME_HEIGHT: cfg_height = int'(value[DIM_W-1:0]);
         default: begin
         end
      endcase
      register_writes++;
   endtask

   task automatic send_request(mode_type kind, int c, int r, bit pol);
      int gap;
      int uw;
      int uh;
      gap = steady ? 0 : $urandom_range(0, 5);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.mode     <= kind;
      req_bus.col      <= COL_W'(c);
      req_bus.row      <= ROW_W'(r);
      req_bus.polarity <= pol;
      do @(posedge clock); while (!req_bus.ready);
      case (kind)
         MODE_START: begin
            uw = used_span(cfg_width, MAX_WIDTH);
            uh = used_span(cfg_height, MAX_HEIGHT);
            for (int y = 0; y < uh; y++)
               for (int x = 0; x < uw; x++)
                  written_pixels[y * MAX_WIDTH + x] = 1'b1;
            sweep_backlog += uw * uh + 4;
            starts_sent++;
         end
         MODE_EVENT: events_sent++;
         MODE_READ:  reads_sent++;
         default:    unused_sent++;
      endcase
   endtask

   // lower valid, wait out every read, then any sweep still running
   task automatic drain_block();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (check_pending != 0) @(negedge clock);
      repeat (sweep_backlog + 16) @(negedge clock);
      sweep_backlog = 0;
   endtask

   task automatic random_item();
      int c;
      int r;
      int pick;
      bit ok;
      bit pol;
      pick = $urandom_range(0, 99);
      ok   = pick_pixel(c, r);
      pol  = ($urandom_range(0, 99) < up_bias);
      if (pick < 2 &&
          used_span(cfg_width, MAX_WIDTH) * used_span(cfg_height, MAX_HEIGHT) <= 4096)
         send_request(MODE_START, $urandom_range(0, 255), $urandom_range(0, 255), pol);
      else if (pick < 5 || !ok)
         send_request(MODE_NONE, $urandom_range(0, 255), $urandom_range(0, 255), pol);
      else if (pick < 65)
         send_request(MODE_EVENT, c, r, pol);
      else
         send_request(MODE_READ, c, r, pol);
   endtask

   function automatic int pick_dim();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 5) return 0;
      if (pick < 10) return $urandom_range(17, 511);
      if (pick < 13) return 511;
      if (pick < 15) return 256;
      return $urandom_range(1, 16);
   endfunction

   function automatic int pick_threshold();
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return 127;
         2, 3:    return $urandom_range(1, 4);
         default: return $urandom_range(0, 127);
      endcase
   endfunction

   function automatic int pick_cap();
      case ($urandom_range(0, 5))
         0:       return 0;
         1:       return $urandom_range(1, 8);
         2:       return $urandom_range(20, 200);
         3:       return 16777215;
         default: return $urandom() & 32'hFF_FFFF;
      endcase
   endfunction

   // response side pacing
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            stall = 300;
         end else begin
            stall = steady ? 0 : $urandom_range(0, 5);
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (psel && penable))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("event_frame_accumulator_core verification failed");
         $finish;
      end
   end

   initial begin
      int random_items;
      int length;
      int c;
      int r;
      bit keep;
      req_bus.valid    = 1'b0;
      req_bus.mode     = MODE_NONE;
      req_bus.col      = '0;
      req_bus.row      = '0;
      req_bus.polarity = 1'b0;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      random_items = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // reset frame size, nothing written yet
      send_request(MODE_READ, 240, 0, 1'b0);
      send_request(MODE_READ, 0, 180, 1'b0);
      send_request(MODE_EVENT, 250, 10, 1'b1);
      send_request(MODE_NONE, 17, 33, 1'b1);
      send_request(MODE_START, 0, 0, 1'b0);
      send_request(MODE_READ, 0, 0, 1'b0);
      send_request(MODE_READ, 239, 179, 1'b0);
      send_request(MODE_EVENT, 239, 179, 1'b1);
      send_request(MODE_READ, 239, 179, 1'b0);
      send_request(MODE_EVENT, 0, 0, 1'b0);
      send_request(MODE_READ, 0, 0, 1'b0);
      send_request(MODE_READ, 255, 255, 1'b1);
      drain_block();

      // clamped width, tiny cap, saturation at both ends
      write_register(REG_THRESHOLD, 1);
      write_register(REG_MAX_EVENTS, 3);
      write_register(REG_FRAME_WIDTH, 511);
      write_register(REG_FRAME_HEIGHT, 2);
      send_request(MODE_START, 5, 5, 1'b1);
      repeat (4) send_request(MODE_EVENT, 255, 1, 1'b1);
      send_request(MODE_READ, 255, 1, 1'b0);
      send_request(MODE_READ, 0, 2, 1'b0);
      send_request(MODE_START, 0, 0, 1'b0);
      send_request(MODE_EVENT, 0, 0, 1'b0);
      send_request(MODE_EVENT, 0, 0, 1'b0);
      send_request(MODE_READ, 0, 0, 1'b0);
      drain_block();

      // threshold lowered under a live frame: pixel sits above the ceiling
      write_register(REG_THRESHOLD, 0);
      send_request(MODE_EVENT, 255, 1, 1'b1);
      send_request(MODE_READ, 255, 1, 1'b0);
      drain_block();

      // long response hold-off while requests keep coming
      write_register(REG_THRESHOLD, 3);
      write_register(REG_MAX_EVENTS, 16777215);
      write_register(REG_FRAME_WIDTH, 8);
      write_register(REG_FRAME_HEIGHT, 8);
      send_request(MODE_START, 0, 0, 1'b0);
      steady = 1'b1;
      hold_off_request = 1'b1;
      for (int i = 0; i < 40; i++) begin
         void'(pick_pixel(c, r));
         send_request((i % 2 == 0) ? MODE_EVENT : MODE_READ, c, r,
                      1'($urandom_range(0, 1)));
      end
      steady = 1'b0;
      drain_block();

      while (random_items < RANDOM_ITEMS) begin
         phases++;
         keep    = ($urandom_range(0, 4) == 0);
         steady  = ($urandom_range(0, 4) == 0);
         up_bias = $urandom_range(20, 80);
         write_register(REG_THRESHOLD, pick_threshold());
         write_register(REG_MAX_EVENTS, pick_cap());
         if (!keep) begin
            write_register(REG_FRAME_WIDTH, pick_dim());
            write_register(REG_FRAME_HEIGHT, pick_dim());
            send_request(MODE_START, $urandom_range(0, 255), $urandom_range(0, 255),
                         1'($urandom_range(0, 1)));
         end
         length = $urandom_range(40, 120);
         repeat (length) random_item();
         random_items += length;
         drain_block();
      end

      $display("covered %0d frame starts, %0d events, %0d pixel reads, %0d unused-mode requests",
               starts_sent, events_sent, reads_sent, unused_sent);
      $display("%0d register writes over %0d random phases, %0d read responses compared",
               register_writes, phases, check_reads);
      if (check_failures == 0 && check_pending == 0)
         $display("event_frame_accumulator_core verification clean");
      else
         $display("event_frame_accumulator_core verification failed");
      $finish;
   end

endmodule
